/* hw/rtl/stuffed_frame_receiver_crc16_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the stuffed frame receiver
// Shared helpers that wrap concurrent assertions in the house form.
// ----------------------------------------------------------------------------
`ifndef STUFFED_FRAME_RECEIVER_CRC16_DEFINES_SVH
`define STUFFED_FRAME_RECEIVER_CRC16_DEFINES_SVH

// Implication checked on the same edge, skipped while reset is asserted.
`define SFR_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked on the following edge, active during reset as well.
`define SFR_ASSERT_NEXT(lbl, clk_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/sfr_pkg.sv */
// ----------------------------------------------------------------------------
// Stuffed frame receiver package
// Constants, result type and the byte-wise CRC-16 step.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  localparam int FRAME_BYTES_DEF = 64;

  localparam logic [7:0] FLAG_BYTE     = 8'h7E;
  localparam logic [7:0] ESC_BYTE      = 8'h7D;
  localparam logic [7:0] ESC_XOR       = 8'h20;
  localparam logic [7:0] TYPE_ACK      = 8'h43;
  localparam logic [7:0] TYPE_DATA     = 8'h45;
  localparam logic [7:0] MODULE_ID_RST = 8'h5E;
  localparam logic [7:0] CMD_SENSOR    = 8'h01;
  localparam logic [7:0] SENSOR_ARG0   = 8'h05;
  localparam logic [7:0] SENSOR_ARG1   = 8'h0A;
  localparam logic [7:0] CMD_FAN       = 8'h03;
  localparam logic [7:0] FAN_ON_ARG    = 8'h11;
  localparam logic [7:0] FAN_OFF_ARG   = 8'h12;

  typedef enum logic [2:0] {
    ST_ACK,
    ST_SENSOR,
    ST_FAN_ON,
    ST_FAN_OFF,
    ST_OTHER,
    ST_CRC_ERR
  } sfr_status_t;

  typedef enum logic [1:0] {
    FAN_UNKNOWN,
    FAN_ON,
    FAN_OFF
  } sfr_fan_t;

  typedef struct packed {
    logic [5:0]  frame_length;
    logic [15:0] humi_raw;
    logic [15:0] temp_raw;
    sfr_fan_t    fan_state;
    sfr_status_t frame_status;
  } sfr_result_t;

  localparam int RESULT_W   = $bits(sfr_result_t);
  localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

  // One byte of CRC-16/XMODEM (poly 0x1021, no reflection).
  function automatic logic [15:0] crc16_step(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = {crc_in[7:0], crc_in[15:8]};
    c[7:0] = c[7:0] ^ data;
    c = c ^ {12'h000, c[7:4]};
    c = c ^ {c[3:0], 12'h000};
    c = c ^ {3'b000, c[7:0], 5'b00000};
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/sfr_deframer.sv */
// ----------------------------------------------------------------------------
// Stuffed frame receiver deframer
// Per-byte destuffing, field capture, CRC and frame classification.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_deframer #(
  parameter int FRAME_BYTES = sfr_pkg::FRAME_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire logic [7:0]         rx_byte,
  input  wire logic [7:0]         dev_id,
  output logic                    emit,
  output sfr_pkg::sfr_result_t    result
);
  import sfr_pkg::*;

  // Count must reach the sensor offsets and the six-bit length field.
  localparam int CNT_W = ($clog2(FRAME_BYTES) > 6) ? $clog2(FRAME_BYTES) : 6;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_BYTES - 1);

  logic             last_flag_r, last_flag_nxt;
  logic             in_frame_r, in_frame_nxt;
  logic             esc_r, esc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       tail_r [2];
  logic [7:0]       tail_nxt [2];
  logic [7:0]       hdr_r [5];
  logic [7:0]       hdr_nxt [5];
  logic [15:0]      temp_r, temp_nxt;
  logic [15:0]      humi_r, humi_nxt;
  sfr_fan_t         fan_r, fan_nxt;

  logic             is_flag;
  logic [7:0]       dbyte;
  sfr_status_t      cls_status;
  sfr_fan_t         cls_fan;

  assign is_flag = (rx_byte == FLAG_BYTE);
  assign dbyte   = esc_r ? (rx_byte ^ ESC_XOR) : rx_byte;
  assign emit    = is_flag && !last_flag_r && in_frame_r;

  // Classification of the frame that the current flag closes.
  always_comb begin
    cls_status = ST_OTHER;
    cls_fan    = fan_r;
    if (cnt_r < CNT_W'(2)) begin
      cls_status = ST_CRC_ERR;
    end else if (crc_r != {tail_r[1], tail_r[0]}) begin
      cls_status = ST_CRC_ERR;
    end else if (cnt_r >= CNT_W'(3) && hdr_r[0] == TYPE_ACK) begin
      cls_status = ST_ACK;
    end else if (cnt_r >= CNT_W'(12) && hdr_r[0] == TYPE_DATA &&
                 hdr_r[1] == dev_id) begin
      if (cnt_r >= CNT_W'(21) && hdr_r[2] == CMD_SENSOR &&
          hdr_r[3] == SENSOR_ARG0 && hdr_r[4] == SENSOR_ARG1) begin
        cls_status = ST_SENSOR;
      end else if (cnt_r >= CNT_W'(14) && hdr_r[2] == CMD_FAN) begin
        if (hdr_r[3] == FAN_ON_ARG) begin
          cls_status = ST_FAN_ON;
          cls_fan    = FAN_ON;
        end else if (hdr_r[3] == FAN_OFF_ARG) begin
          cls_status = ST_FAN_OFF;
          cls_fan    = FAN_OFF;
        end
      end
    end
  end

  always_comb begin
    result.frame_status = cls_status;
    result.fan_state    = cls_fan;
    result.temp_raw     = (cls_status == ST_SENSOR) ? temp_r : 16'h0000;
    result.humi_raw     = (cls_status == ST_SENSOR) ? humi_r : 16'h0000;
    result.frame_length = cnt_r[5:0];
  end

  // Next state for one byte.
  always_comb begin
    last_flag_nxt = last_flag_r;
    in_frame_nxt  = in_frame_r;
    esc_nxt       = esc_r;
    cnt_nxt       = cnt_r;
    crc_nxt       = crc_r;
    tail_nxt      = tail_r;
    hdr_nxt       = hdr_r;
    temp_nxt      = temp_r;
    humi_nxt      = humi_r;
    fan_nxt       = fan_r;
    if (step) begin
      last_flag_nxt = is_flag;
      if (is_flag) begin
        esc_nxt = 1'b0;
        if (last_flag_r) begin
          // Two flags in a row start a fresh frame.
          in_frame_nxt = 1'b1;
          cnt_nxt      = '0;
          crc_nxt      = 16'h0000;
          tail_nxt[0]  = 8'h00;
          tail_nxt[1]  = 8'h00;
          for (int i = 0; i < 5; i++) begin
            hdr_nxt[i] = 8'h00;
          end
          temp_nxt = 16'h0000;
          humi_nxt = 16'h0000;
        end else if (in_frame_r) begin
          in_frame_nxt = 1'b0;
          fan_nxt      = cls_fan;
        end
      end else if (in_frame_r) begin
        if (rx_byte == ESC_BYTE) begin
          esc_nxt = 1'b1;
        end else begin
          esc_nxt = 1'b0;
          if (cnt_r >= CNT_LAST) begin
            // Frame too long: drop it without a result.
            in_frame_nxt = 1'b0;
          end else begin
            if (cnt_r >= CNT_W'(2)) begin
              crc_nxt = crc16_step(crc_r, tail_r[0]);
            end
            tail_nxt[0] = tail_r[1];
            tail_nxt[1] = dbyte;
            if (cnt_r == CNT_W'(0))  hdr_nxt[0] = dbyte;
            if (cnt_r == CNT_W'(9))  hdr_nxt[1] = dbyte;
            if (cnt_r == CNT_W'(10)) hdr_nxt[2] = dbyte;
            if (cnt_r == CNT_W'(11)) hdr_nxt[3] = dbyte;
            if (cnt_r == CNT_W'(12)) hdr_nxt[4] = dbyte;
            if (cnt_r == CNT_W'(15)) temp_nxt[7:0]  = dbyte;
            if (cnt_r == CNT_W'(16)) temp_nxt[15:8] = dbyte;
            if (cnt_r == CNT_W'(17)) humi_nxt[7:0]  = dbyte;
            if (cnt_r == CNT_W'(18)) humi_nxt[15:8] = dbyte;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_flag_r <= 1'b1;
      in_frame_r  <= 1'b0;
      esc_r       <= 1'b0;
      cnt_r       <= '0;
      fan_r       <= FAN_UNKNOWN;
    end else begin
      last_flag_r <= last_flag_nxt;
      in_frame_r  <= in_frame_nxt;
      esc_r       <= esc_nxt;
      cnt_r       <= cnt_nxt;
      fan_r       <= fan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r  <= crc_nxt;
    tail_r <= tail_nxt;
    hdr_r  <= hdr_nxt;
    temp_r <= temp_nxt;
    humi_r <= humi_nxt;
  end

endmodule

`default_nettype wire

/* hw/rtl/stuffed_frame_receiver_crc16.sv */
// ----------------------------------------------------------------------------
// Stuffed frame receiver with CRC-16 check
// Deframes a byte-stuffed serial stream and reports one status per frame.
// ----------------------------------------------------------------------------
// Usage: raw line bytes enter on the in_ channel, one byte per transfer. Two
// flag bytes in a row open a frame, a single flag after data closes it, and
// each closed frame that was not dropped for length yields one transfer on the
// out_ channel carrying its status, the kept fan state, the sensor words and
// the decoded length. Bytes that close nothing yield no transfer.
// The cfg_ channel writes the expected module id; it is always ready and is
// meant to be written only while the block is idle.
// Throughput is one byte per cycle except while a closing flag waits on a held
// result: the destuffing, the one-byte CRC step and the field capture all sit
// combinationally between the input register and the result register. A
// closing flag's result is registered with out_tvalid once the flag advances.
// Reset (rst_n low, synchronous) empties both registers, sets the module id
// to its default, forgets the fan state and behaves as if a flag had just
// been seen. When the receiver stalls, the held result stays put and bytes
// that close no frame keep flowing; a closing flag waits in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stuffed_frame_receiver_crc16_defines.svh"

module stuffed_frame_receiver_crc16 #(
  parameter int FRAME_BYTES = sfr_pkg::FRAME_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Raw byte stream.
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,   // [7:0] rx_byte
  // Frame results.
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [2:0] frame_status, [4:3] fan_state, [20:5] temp_raw, [36:21] humi_raw,
  // [42:37] frame_length, upper bits zero
  output logic [sfr_pkg::OUT_DATA_W-1:0]     out_tdata,
  // Module id register.
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [7:0]                    cfg_data    // [7:0] device id
);
  import sfr_pkg::*;

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        out_valid_r;
  sfr_result_t out_res_r;
  logic [7:0]  dev_id_r;

  logic        emit;
  logic        advance;
  sfr_result_t res;

  // The byte in the input register moves on unless it closes a frame while a
  // previous result is still held.
  assign advance   = in_valid_r && (!emit || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  sfr_deframer #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_deframer (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .rx_byte   (in_byte_r),
    .dev_id    (dev_id_r),
    .emit      (emit),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      dev_id_r    <= MODULE_ID_RST;
    end else begin
      if (in_tvalid && in_tready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        dev_id_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (advance && emit) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, out_res_r};

  `SFR_ASSERT_NEXT(a_reset_empties_output, clk, !rst_n, !out_tvalid,
                   "result valid right after reset")
  `SFR_ASSERT_IMPL(a_status_in_range, clk, rst_n, out_tvalid,
                   out_res_r.frame_status == ST_ACK ||
                   out_res_r.frame_status == ST_SENSOR ||
                   out_res_r.frame_status == ST_FAN_ON ||
                   out_res_r.frame_status == ST_FAN_OFF ||
                   out_res_r.frame_status == ST_OTHER ||
                   out_res_r.frame_status == ST_CRC_ERR,
                   "frame status out of range")
  `SFR_ASSERT_IMPL(a_fan_on_state, clk, rst_n,
                   out_tvalid && out_res_r.frame_status == ST_FAN_ON,
                   out_res_r.fan_state == FAN_ON, "fan on report without fan on state")
  `SFR_ASSERT_IMPL(a_fan_off_state, clk, rst_n,
                   out_tvalid && out_res_r.frame_status == ST_FAN_OFF,
                   out_res_r.fan_state == FAN_OFF, "fan off report without fan off state")
  `SFR_ASSERT_IMPL(a_words_only_sensor, clk, rst_n,
                   out_tvalid && out_res_r.frame_status != ST_SENSOR,
                   out_res_r.temp_raw == 16'h0000 && out_res_r.humi_raw == 16'h0000,
                   "sensor words on a non-sensor result")

endmodule

`default_nettype wire
